// File: rtl/swt_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and defaults for the stop-and-wait retransmit timer.
package swt_pkg;

    // Width of the timeout register and of timeout_out
    localparam int TO_W = 24;

    localparam int SEQ_BITS_DEF       = 16;
    localparam int TAG_BITS_DEF       = 16;
    localparam int TIME_BITS_DEF      = 32;
    localparam int MAX_TIMEOUT_US_DEF = 100000;

    localparam logic [TO_W-1:0] TIMEOUT_RESET = TO_W'(100000);

    // APB register map
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] ADDR_INIT_TIMEOUT = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] ADDR_ADAPT_EN     = 3'd4;

    typedef enum logic [1:0] {
        REQ_ADD  = 2'd0,
        REQ_POLL = 2'd1,
        REQ_ACK  = 2'd2
    } t_req_type;

    typedef enum logic [1:0] {
        ACK_ACCEPTED = 2'd0,
        ACK_EMPTY    = 2'd1,
        ACK_MISMATCH = 2'd2,
        ACK_NONE     = 2'd3
    } t_ack_status;

endpackage

// File: rtl/swt_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces of the retransmit timer.
interface swt_req_if #(
    parameter int SEQ_BITS  = swt_pkg::SEQ_BITS_DEF,
    parameter int TAG_BITS  = swt_pkg::TAG_BITS_DEF,
    parameter int TIME_BITS = swt_pkg::TIME_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           req_type;
    logic [SEQ_BITS-1:0]  seq_num;
    logic [TAG_BITS-1:0]  packet_tag;
    logic [TIME_BITS-1:0] now_us;

    modport source (output valid, output req_type, output seq_num, output packet_tag,
                    output now_us, input ready);
    modport sink   (input valid, input req_type, input seq_num, input packet_tag,
                    input now_us, output ready);
endinterface

interface swt_rsp_if #(
    parameter int TAG_BITS = swt_pkg::TAG_BITS_DEF
);
    logic                      valid;
    logic                      ready;
    logic                      send_packet;
    logic [TAG_BITS-1:0]       tag_out;
    logic                      slot_free;
    logic [1:0]                ack_status;
    logic [swt_pkg::TO_W-1:0]  timeout_out;

    modport source (output valid, output send_packet, output tag_out, output slot_free,
                    output ack_status, output timeout_out, input ready);
    modport sink   (input valid, input send_packet, input tag_out, input slot_free,
                    input ack_status, input timeout_out, output ready);
endinterface

// File: rtl/stop_and_wait_retransmit_timer_top.sv
`timescale 1ns / 1ps
// Stop-and-wait ARQ sender timer: holds one packet, answers adds, polls and acks.
//
// Takes one request word per clock while responses are taken, and returns one
// response word per request. A word passes an input register and a result
// register, so its response is presented once the result register loads; the
// held-packet state and the running timeout are updated when the result register
// loads, and the next word sees that state. While a finished response waits, the
// input takes one more word into the input register and then stalls until the
// response is taken.
// Configuration is written over APB:
// offset 0x0 initial_timeout_us (loads the running timeout), offset 0x4
// adaptive_enable. Write registers only while no request is in flight.
module stop_and_wait_retransmit_timer_top #(
    parameter int SEQ_BITS       = swt_pkg::SEQ_BITS_DEF,
    parameter int TAG_BITS       = swt_pkg::TAG_BITS_DEF,
    parameter int TIME_BITS      = swt_pkg::TIME_BITS_DEF,
    parameter int MAX_TIMEOUT_US = swt_pkg::MAX_TIMEOUT_US_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    swt_req_if.sink                           i_req,
    swt_rsp_if.source                         o_rsp,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [swt_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [swt_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [swt_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int TO_W  = swt_pkg::TO_W;
    localparam int CMP_W = (TIME_BITS > TO_W) ? TIME_BITS : TO_W;

    // Configuration registers
    logic [TO_W-1:0] r_init_timeout;
    logic            r_adapt_en;

    // Input register
    logic                 r_s1_valid;
    logic [1:0]           r_s1_req;
    logic [SEQ_BITS-1:0]  r_s1_seq;
    logic [TAG_BITS-1:0]  r_s1_tag;
    logic [TIME_BITS-1:0] r_s1_now;

    // Held packet state
    logic                 r_holding,    n_holding;
    logic [SEQ_BITS-1:0]  r_held_seq,   n_held_seq;
    logic [TAG_BITS-1:0]  r_held_tag,   n_held_tag;
    logic [TIME_BITS-1:0] r_first_time, n_first_time;
    logic [TIME_BITS-1:0] r_last_time,  n_last_time;
    logic [TO_W-1:0]      r_timeout,    n_timeout;

    // Result register
    logic                 r_out_valid;
    logic                 r_send,   n_send;
    logic [TAG_BITS-1:0]  r_tag_out, n_tag_out;
    logic [1:0]           r_status, n_status;

    logic                 cfg_wr;
    logic                 s2_load;
    logic                 s1_load;
    logic [TIME_BITS-1:0] age_last;
    logic [TIME_BITS-1:0] age_first;
    logic [CMP_W:0]       mean_sum;
    logic [CMP_W-1:0]     mean;
    logic [CMP_W-1:0]     mean_capped;

    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign prdata  = paddr[2] ? swt_pkg::CFG_DATA_W'(r_adapt_en)
                              : swt_pkg::CFG_DATA_W'(r_init_timeout);

    assign s2_load     = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign s1_load     = i_req.valid && i_req.ready;
    assign i_req.ready = !r_s1_valid || s2_load;

    assign age_last  = r_s1_now - r_last_time;
    assign age_first = r_s1_now - r_first_time;
    assign mean_sum  = (CMP_W + 1)'(age_first) + (CMP_W + 1)'(r_timeout);
    assign mean      = mean_sum[CMP_W:1];
    assign mean_capped = (mean > CMP_W'(MAX_TIMEOUT_US)) ? CMP_W'(MAX_TIMEOUT_US) : mean;

    always_comb begin
        n_holding    = r_holding;
        n_held_seq   = r_held_seq;
        n_held_tag   = r_held_tag;
        n_first_time = r_first_time;
        n_last_time  = r_last_time;
        n_timeout    = r_timeout;
        n_send       = 1'b0;
        n_tag_out    = '0;
        n_status     = swt_pkg::ACK_NONE;
        case (r_s1_req)
            swt_pkg::REQ_ADD: begin
                n_holding    = 1'b1;
                n_held_seq   = r_s1_seq;
                n_held_tag   = r_s1_tag;
                n_first_time = r_s1_now;
                n_last_time  = r_s1_now;
            end
            swt_pkg::REQ_POLL: begin
                if (r_holding && (CMP_W'(age_last) > CMP_W'(r_timeout))) begin
                    n_send      = 1'b1;
                    n_tag_out   = r_held_tag;
                    n_last_time = r_s1_now;
                end
            end
            swt_pkg::REQ_ACK: begin
                if (!r_holding) begin
                    n_status = swt_pkg::ACK_EMPTY;
                end else if (r_s1_seq != r_held_seq) begin
                    n_status = swt_pkg::ACK_MISMATCH;
                end else begin
                    n_status  = swt_pkg::ACK_ACCEPTED;
                    n_holding = 1'b0;
                    if (r_adapt_en) begin
                        n_timeout = TO_W'(mean_capped);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Control and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_timeout <= swt_pkg::TIMEOUT_RESET;
            r_adapt_en     <= 1'b0;
            r_timeout      <= swt_pkg::TIMEOUT_RESET;
            r_holding      <= 1'b0;
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (cfg_wr && !paddr[2]) begin
                r_init_timeout <= pwdata[TO_W-1:0];
                r_timeout      <= pwdata[TO_W-1:0];
            end else if (s2_load) begin
                r_timeout <= n_timeout;
            end
            if (cfg_wr && paddr[2]) begin
                r_adapt_en <= pwdata[0];
            end
            if (s2_load) begin
                r_holding <= n_holding;
            end
            if (i_req.ready) begin
                r_s1_valid <= i_req.valid;
            end
            // hold the response until taken
            if (s2_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_req <= i_req.req_type;
            r_s1_seq <= i_req.seq_num;
            r_s1_tag <= i_req.packet_tag;
            r_s1_now <= i_req.now_us;
        end
        if (s2_load) begin
            r_held_seq   <= n_held_seq;
            r_held_tag   <= n_held_tag;
            r_first_time <= n_first_time;
            r_last_time  <= n_last_time;
            r_send       <= n_send;
            r_tag_out    <= n_tag_out;
            r_status     <= n_status;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.send_packet = r_send;
    assign o_rsp.tag_out     = r_tag_out;
    assign o_rsp.slot_free   = !r_holding;
    assign o_rsp.ack_status  = r_status;
    assign o_rsp.timeout_out = r_timeout;

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the stop-and-wait retransmit timer: directed and random traffic.
module tb;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 4;

    typedef enum {RX_FREE, RX_RANDOM, RX_PERIODIC, RX_BURSTY} t_rx_mode;

    typedef struct {
        logic                     send_pkt;
        logic [15:0]              tag;
        logic                     slot_free;
        swt_pkg::t_ack_status     status;
        logic [swt_pkg::TO_W-1:0] rto;
    } t_timer_rsp;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [swt_pkg::CFG_ADDR_W-1:0] paddr;
    logic [swt_pkg::CFG_DATA_W-1:0] pwdata;
    logic [swt_pkg::CFG_DATA_W-1:0] prdata;
    logic        pready;

    swt_req_if req_bus ();
    swt_rsp_if rsp_bus ();

    stop_and_wait_retransmit_timer_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Timer state as seen from outside, plus configuration
    logic                     pkt_held = 1'b0;
    logic [15:0]              pkt_seq = '0;
    logic [15:0]              pkt_tag = '0;
    logic [31:0]              sent_first = '0;
    logic [31:0]              sent_last = '0;
    logic [swt_pkg::TO_W-1:0] rto_us = swt_pkg::TIMEOUT_RESET;
    logic                     adapt_on = 1'b0;

    t_timer_rsp expected_rsp[$];
    int         errors = 0;
    int         burst_left = 0;
    logic [31:0] clock_us = '0;

    t_rx_mode   rx_mode = RX_FREE;
    int         rx_cyc = 0;
    int         rx_hold = 0;

    function automatic t_timer_rsp timer_step(logic [1:0] kind, logic [15:0] seq,
                                              logic [15:0] tag, logic [31:0] now);
        t_timer_rsp r;
        logic [31:0] age;
        logic [32:0] mean;
        r.send_pkt = 1'b0;
        r.tag      = '0;
        r.status   = swt_pkg::ACK_NONE;
        case (kind)
            swt_pkg::REQ_ADD: begin
                pkt_held   = 1'b1;
                pkt_seq    = seq;
                pkt_tag    = tag;
                sent_first = now;
                sent_last  = now;
            end
            swt_pkg::REQ_POLL: begin
                age = now - sent_last;
                if (pkt_held && age > {8'd0, rto_us}) begin
                    r.send_pkt = 1'b1;
                    r.tag      = pkt_tag;
                    sent_last  = now;
                end
            end
            swt_pkg::REQ_ACK: begin
                if (!pkt_held) begin
                    r.status = swt_pkg::ACK_EMPTY;
                end else if (seq != pkt_seq) begin
                    r.status = swt_pkg::ACK_MISMATCH;
                end else begin
                    r.status = swt_pkg::ACK_ACCEPTED;
                    if (adapt_on) begin
                        age  = now - sent_first;
                        // floor of the mean without a carry out of the sum
                        mean = 33'(age >> 1) + 33'(rto_us >> 1) + 33'(age[0] & rto_us[0]);
                        if (mean > 33'(swt_pkg::MAX_TIMEOUT_US_DEF))
                            mean = 33'(swt_pkg::MAX_TIMEOUT_US_DEF);
                        rto_us = mean[swt_pkg::TO_W-1:0];
                    end
                    pkt_held = 1'b0;
                end
            end
            default: ;
        endcase
        r.slot_free = !pkt_held;
        r.rto       = rto_us;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // Predict on every accepted request word, check every accepted response word
    always @(posedge i_clk) begin
        t_timer_rsp exp_r;
        if (i_rst_n) begin
            if (req_bus.valid && req_bus.ready)
                expected_rsp.push_back(timer_step(req_bus.req_type, req_bus.seq_num,
                                                  req_bus.packet_tag, req_bus.now_us));
            if (rsp_bus.valid && rsp_bus.ready) begin
                if (expected_rsp.size() == 0) begin
                    $display("%0t: unexpected response word, expected none, actual tag %0h",
                             $time, rsp_bus.tag_out);
                    errors++;
                end else begin
                    exp_r = expected_rsp.pop_front();
                    check_field("send_packet", exp_r.send_pkt, rsp_bus.send_packet);
                    check_field("tag_out", exp_r.tag, rsp_bus.tag_out);
                    check_field("slot_free", exp_r.slot_free, rsp_bus.slot_free);
                    check_field("ack_status", exp_r.status, rsp_bus.ack_status);
                    check_field("timeout_out", exp_r.rto, rsp_bus.timeout_out);
                end
            end
        end
    end

    // Response backpressure on its own pattern, switching to a randomly chosen style
    always @(negedge i_clk) begin
        rx_cyc++;
        if (rx_cyc % 256 == 0)
            rx_mode = t_rx_mode'($urandom_range(0, 3));
        case (rx_mode)
            RX_FREE:     rsp_bus.ready = 1'b1;
            RX_RANDOM:   rsp_bus.ready = ($urandom_range(0, 9) > 2);
            RX_PERIODIC: rsp_bus.ready = (rx_cyc % 4 != 0);
            default: begin
                if (rx_hold > 0) begin
                    rx_hold--;
                    rsp_bus.ready = 1'b0;
                end else if ($urandom_range(0, 15) == 0) begin
                    rx_hold = $urandom_range(1, 12);
                    rsp_bus.ready = 1'b0;
                end else begin
                    rsp_bus.ready = 1'b1;
                end
            end
        endcase
    end

    task automatic cfg_write(logic [swt_pkg::CFG_ADDR_W-1:0] addr,
                             logic [swt_pkg::CFG_DATA_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == swt_pkg::ADDR_INIT_TIMEOUT)
            rto_us = data[swt_pkg::TO_W-1:0];
        else if (addr == swt_pkg::ADDR_ADAPT_EN)
            adapt_on = data[0];
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Call at a falling edge; returns at the falling edge after the word is taken
    task automatic send_word(logic [1:0] kind, logic [15:0] seq, logic [15:0] tag,
                             logic [31:0] now);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                req_bus.valid = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        req_bus.valid      = 1'b1;
        req_bus.req_type   = kind;
        req_bus.seq_num    = seq;
        req_bus.packet_tag = tag;
        req_bus.now_us     = now;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        req_bus.valid = 1'b0;
        while (expected_rsp.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Advance the clock by a tiny step or by up to about twice the timeout
    function automatic logic [31:0] next_time(int unsigned span);
        if ($urandom_range(0, 1) == 0)
            clock_us = clock_us + $urandom_range(0, 3);
        else
            clock_us = clock_us + $urandom_range(0, 2 * span + 2);
        return clock_us;
    endfunction

    task automatic test_slot_handling();
        send_word(swt_pkg::REQ_POLL, 16'h0000, 16'h0000, 32'h0000_0000);
        send_word(swt_pkg::REQ_ACK, 16'hFFFF, 16'h0000, 32'h0000_0000);
        send_word(REQ_UNUSED, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_word(swt_pkg::REQ_ADD, 16'hFFFF, 16'hFFFF, 32'h0000_0000);
        send_word(swt_pkg::REQ_POLL, 16'h0000, 16'h0000, 32'd100000);   // age equals timeout
        send_word(swt_pkg::REQ_POLL, 16'h0000, 16'h0000, 32'd100001);
        send_word(swt_pkg::REQ_ACK, 16'h0000, 16'h0000, 32'd100002);
        // replace the held packet, then age across the counter wrap
        send_word(swt_pkg::REQ_ADD, 16'h1234, 16'h0000, 32'hFFFF_FFF0);
        send_word(swt_pkg::REQ_ACK, 16'hFFFF, 16'h0000, 32'hFFFF_FFF1);
        send_word(swt_pkg::REQ_POLL, 16'h0000, 16'h0000, 32'h0001_86A0);
        send_word(swt_pkg::REQ_ACK, 16'h1234, 16'hFFFF, 32'h0001_86A1);
        send_word(swt_pkg::REQ_POLL, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        wait_idle();
    endtask

    task automatic test_adaptive_timeout();
        cfg_write(swt_pkg::ADDR_INIT_TIMEOUT, 32'h00FF_FFFF);
        cfg_write(swt_pkg::ADDR_ADAPT_EN, 32'd1);
        send_word(swt_pkg::REQ_ADD, 16'h0000, 16'hA5A5, 32'h0000_0000);
        send_word(swt_pkg::REQ_POLL, 16'h0000, 16'h0000, 32'h00FF_FFFF);
        send_word(swt_pkg::REQ_POLL, 16'h0000, 16'h0000, 32'h0100_0000);
        send_word(swt_pkg::REQ_ACK, 16'h0000, 16'h0000, 32'hFFFF_FFFF);   // capped
        wait_idle();
        cfg_write(swt_pkg::ADDR_INIT_TIMEOUT, 32'd7);
        send_word(swt_pkg::REQ_ADD, 16'h0005, 16'h0001, 32'hFFFF_FFFE);
        // odd age plus odd timeout, so the mean is exact
        send_word(swt_pkg::REQ_ACK, 16'h0005, 16'h0000, 32'h0000_0003);
        wait_idle();
        cfg_write(swt_pkg::ADDR_INIT_TIMEOUT, 32'd0);
        send_word(swt_pkg::REQ_ADD, 16'h0009, 16'h5A5A, 32'd100);
        send_word(swt_pkg::REQ_POLL, 16'h0000, 16'h0000, 32'd100);
        send_word(swt_pkg::REQ_POLL, 16'h0000, 16'h0000, 32'd101);
        send_word(swt_pkg::REQ_ACK, 16'h0009, 16'h0000, 32'd101);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        logic [23:0] rto_set[7];
        logic        adapt_set[7];
        int unsigned span;
        int          sent;
        logic [15:0] seq;
        logic [15:0] seq_ack;
        rto_set   = '{24'd0, 24'd1, 24'd100000, 24'hFFFFFF, 24'd0, 24'd0, 24'd0};
        adapt_set = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
        rto_set[4] = $urandom_range(0, 200000);
        rto_set[5] = $urandom_range(0, 24'hFFFFFF);
        rto_set[6] = $urandom_range(0, 50);
        foreach (rto_set[p]) begin
            cfg_write(swt_pkg::ADDR_INIT_TIMEOUT, {8'd0, rto_set[p]});
            cfg_write(swt_pkg::ADDR_ADAPT_EN, {31'd0, adapt_set[p]});
            span = rto_set[p];
            clock_us = $urandom;
            sent = 0;
            while (sent < 140) begin
                if ($urandom_range(0, 9) < 8) begin
                    // add, a few polls, then an ack that mostly matches
                    seq = $urandom;
                    send_word(swt_pkg::REQ_ADD, seq, 16'($urandom), next_time(span));
                    sent++;
                    repeat ($urandom_range(0, 4)) begin
                        send_word(swt_pkg::REQ_POLL, 16'($urandom), 16'($urandom),
                                  next_time(span));
                        sent++;
                    end
                    seq_ack = seq;
                    if ($urandom_range(0, 6) == 0)
                        seq_ack[$urandom_range(0, 15)] ^= 1'b1;
                    send_word(swt_pkg::REQ_ACK, seq_ack, 16'($urandom), next_time(span));
                    sent++;
                    if ($urandom_range(0, 9) == 0) begin
                        send_word(swt_pkg::REQ_ACK, seq, 16'($urandom), next_time(span));
                        sent++;
                    end
                end else begin
                    if ($urandom_range(0, 1) == 0)
                        clock_us = $urandom;
                    send_word(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                              next_time(span));
                    sent++;
                end
            end
            wait_idle();
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        req_bus.valid      = 1'b0;
        req_bus.req_type   = swt_pkg::REQ_ADD;
        req_bus.seq_num    = '0;
        req_bus.packet_tag = '0;
        req_bus.now_us     = '0;
        rsp_bus.ready      = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_slot_handling();
        test_adaptive_timeout();
        test_random_traffic();

        wait_idle();
        repeat (10) @(negedge i_clk);
        if (errors == 0 && expected_rsp.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #6000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/swt_pkg.sv
rtl/swt_if.sv
rtl/stop_and_wait_retransmit_timer_top.sv
dv/tb.sv
